// ===== hw/rtl/jssl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package jssl_pkg;

  // Default build options
  localparam int FRACTION_BITS_DEF  = 2;
  localparam int DEADBAND_WIDTH_DEF = 512;

  // Field and datapath widths
  localparam int SAMPLE_W   = 12;
  localparam int TIME_W     = 32;
  localparam int HOLD_W     = 16;
  localparam int MODE_W     = 4;
  localparam int MODE_CNT   = 2 ** MODE_W;
  localparam int SPEED_W    = 16;   // stored speed, fixed point
  localparam int OUT_W      = 11;   // speed field of a result word
  localparam int DZ_W       = 15;   // signed deadband output
  localparam int STEP_W     = 13;   // accel step per tick
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  // Top speeds and ramps (per second, before fraction scaling)
  localparam int BASE_AXIAL_TOP   = 300;
  localparam int BASE_YAW_TOP     = 30;
  localparam int BASE_SWEEP_TOP   = 15;
  localparam int MODE_DIVISOR     = 3;
  localparam int TICKS_PER_SEC    = 20;
  localparam int ACCEL_AX_DRIVE   = 600;
  localparam int ACCEL_AX_STOP    = 1024;
  localparam int ACCEL_YAW_TURN   = 800;
  localparam int ACCEL_YAW_SWEEP  = 200;
  localparam int ACCEL_YAW_STOP   = 2048;
  localparam int POT_ACCEL        = 2048;

  // Pot scaling: deadband output is full scale 2^DZ_SCALE_LOG2
  localparam int DZ_SCALE_LOG2  = 11;
  localparam int DZ_FULL_SCALE  = 2 ** DZ_SCALE_LOG2;
  localparam int PRODUCT_SHIFT  = 11;
  localparam int RECIP_SHIFT    = 23;
  localparam int RECIP_W        = 25;

  // Output saturation
  localparam int OUT_MAX = 1023;
  localparam int OUT_MIN = -1024;

  // Result queue
  localparam int FIFO_DEPTH = 4;

  // Config reset values
  localparam logic [SAMPLE_W-1:0] CENTER_RST = SAMPLE_W'(2048);
  localparam logic [HOLD_W-1:0]   HOLD_RST   = HOLD_W'(1000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE       = 3'd0,
    CFG_POT_MODE     = 3'd1,
    CFG_AXIAL_CENTER = 3'd2,
    CFG_YAW_CENTER   = 3'd3,
    CFG_SPEED_MODE   = 3'd4,
    CFG_STOP_HOLD    = 3'd5
  } cfg_idx_t;

  typedef enum logic {
    CMD_SPEED = 1'b0,
    CMD_ESTOP = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    logic forward;
    logic reverse;
    logic right;
    logic left;
    logic stop;
  } btn_t;

  typedef struct packed {
    cmd_kind_t                kind;
    logic signed [OUT_W-1:0]  axial;
    logic signed [OUT_W-1:0]  yaw;
    logic                     last;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/joystick_speed_slew_limiter_unit.sv =====
// Path: input register, deadband register, then the result queue.
// Throughput: one input word per cycle while in_stall is low. A tick on the
//   first stop press makes two result words; the output drains one word per
//   cycle while out_stall is low, through a 4-entry queue.
// Reset (rst_n low, synchronous): pipeline, queue and stop/speed state cleared,
//   config registers back to defaults. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module joystick_speed_slew_limiter_unit import jssl_pkg::*; #(
  parameter int FRACTION_BITS  = FRACTION_BITS_DEF,
  parameter int DEADBAND_WIDTH = DEADBAND_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // input words, one per 50 ms tick
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_forward_pressed,
  input  logic                    in_reverse_pressed,
  input  logic                    in_right_pressed,
  input  logic                    in_left_pressed,
  input  logic                    in_stop_pressed,
  input  logic [SAMPLE_W-1:0]     in_axial_sample,
  input  logic [SAMPLE_W-1:0]     in_yaw_sample,
  input  logic [TIME_W-1:0]       in_now_ms,
  // result words
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_command_kind,
  output logic signed [OUT_W-1:0] out_axial_speed,
  output logic signed [OUT_W-1:0] out_yaw_speed,
  output logic                    out_last_of_tick,
  // config writes
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int PtrW     = $clog2(FIFO_DEPTH);
  localparam int CntW     = $clog2(FIFO_DEPTH + 1);
  localparam int ProdW    = SPEED_W + DZ_W;
  localparam int ShiftedW = ProdW - PRODUCT_SHIFT;

  // per-tick accel steps, fraction scaled
  localparam int AccAxDrive  = (ACCEL_AX_DRIVE << FRACTION_BITS) / TICKS_PER_SEC;
  localparam int AccAxStop   = (ACCEL_AX_STOP << FRACTION_BITS) / TICKS_PER_SEC;
  localparam int AccYawTurn  = (ACCEL_YAW_TURN << FRACTION_BITS) / TICKS_PER_SEC;
  localparam int AccYawSweep = (ACCEL_YAW_SWEEP << FRACTION_BITS) / TICKS_PER_SEC;
  localparam int AccYawStop  = (ACCEL_YAW_STOP << FRACTION_BITS) / TICKS_PER_SEC;

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  logic                enable_r;
  logic                pot_mode_r;
  logic [SAMPLE_W-1:0] axial_center_r;
  logic [SAMPLE_W-1:0] yaw_center_r;
  logic [MODE_W-1:0]   speed_mode_r;   // two's complement bits, table index
  logic [HOLD_W-1:0]   stop_hold_ms_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r       <= 1'b0;
      pot_mode_r     <= 1'b0;
      axial_center_r <= CENTER_RST;
      yaw_center_r   <= CENTER_RST;
      speed_mode_r   <= '0;
      stop_hold_ms_r <= HOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ENABLE:       enable_r       <= cfg_wdata[0];
        CFG_POT_MODE:     pot_mode_r     <= cfg_wdata[0];
        CFG_AXIAL_CENTER: axial_center_r <= cfg_wdata[SAMPLE_W-1:0];
        CFG_YAW_CENTER:   yaw_center_r   <= cfg_wdata[SAMPLE_W-1:0];
        CFG_SPEED_MODE:   speed_mode_r   <= cfg_wdata[MODE_W-1:0];
        CFG_STOP_HOLD:    stop_hold_ms_r <= cfg_wdata[HOLD_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Top speed tables: (base << F) * (3 + mode) / 3, truncated, per mode code
  // ---------------------------------------------------------------------------
  logic signed [SPEED_W-1:0] axial_top_tbl [MODE_CNT];
  logic signed [SPEED_W-1:0] yaw_top_tbl   [MODE_CNT];
  logic signed [SPEED_W-1:0] sweep_top_tbl [MODE_CNT];

  for (genvar k = 0; k < MODE_CNT; k++) begin : g_top
    localparam int ModeVal  = (k >= MODE_CNT / 2) ? k - MODE_CNT : k;
    localparam int AxialTop =
        ((BASE_AXIAL_TOP << FRACTION_BITS) * (MODE_DIVISOR + ModeVal)) / MODE_DIVISOR;
    localparam int YawTop   =
        ((BASE_YAW_TOP << FRACTION_BITS) * (MODE_DIVISOR + ModeVal)) / MODE_DIVISOR;
    localparam int SweepTop =
        ((BASE_SWEEP_TOP << FRACTION_BITS) * (MODE_DIVISOR + ModeVal)) / MODE_DIVISOR;
    assign axial_top_tbl[k] = SPEED_W'(AxialTop);
    assign yaw_top_tbl[k]   = SPEED_W'(YawTop);
    assign sweep_top_tbl[k] = SPEED_W'(SweepTop);
  end

  logic signed [SPEED_W-1:0] top_axial;
  logic signed [SPEED_W-1:0] top_yaw;
  logic signed [SPEED_W-1:0] top_sweep;

  assign top_axial = axial_top_tbl[speed_mode_r];
  assign top_yaw   = yaw_top_tbl[speed_mode_r];
  assign top_sweep = sweep_top_tbl[speed_mode_r];

  // ---------------------------------------------------------------------------
  // Pipeline control: s1 = input register, s2 = deadband register.
  // s2 retires into the result queue only when two slots are free.
  // ---------------------------------------------------------------------------
  logic [CntW-1:0] cnt_r;
  logic            s1_valid_r;
  logic            s2_valid_r;
  logic            s2_go;
  logic            s2_ready;
  logic            s1_go;
  logic            s1_ready;
  logic            in_take;

  assign s2_go    = s2_valid_r && (cnt_r <= CntW'(FIFO_DEPTH - 2));
  assign s2_ready = !s2_valid_r || s2_go;
  assign s1_go    = s1_valid_r && s2_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_stall = !s1_ready;
  assign in_take  = in_valid && s1_ready;

  // s1: raw word
  btn_t                s1_btn_r;
  logic [SAMPLE_W-1:0] s1_axial_r;
  logic [SAMPLE_W-1:0] s1_yaw_r;
  logic [TIME_W-1:0]   s1_now_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_btn_r   <= '{forward: in_forward_pressed, reverse: in_reverse_pressed,
                      right: in_right_pressed, left: in_left_pressed,
                      stop: in_stop_pressed};
      s1_axial_r <= in_axial_sample;
      s1_yaw_r   <= in_yaw_sample;
      s1_now_r   <= in_now_ms;
    end
  end

  // deadband + rescale, one reciprocal multiply per axis
  logic signed [DZ_W-1:0] axial_dz;
  logic signed [DZ_W-1:0] yaw_dz;

  jssl_deadband #(.DEADBAND_WIDTH(DEADBAND_WIDTH)) u_dz_axial (
    .sample (s1_axial_r),
    .center (axial_center_r),
    .axis   (axial_dz)
  );

  jssl_deadband #(.DEADBAND_WIDTH(DEADBAND_WIDTH)) u_dz_yaw (
    .sample (s1_yaw_r),
    .center (yaw_center_r),
    .axis   (yaw_dz)
  );

  // s2
  btn_t                   s2_btn_r;
  logic [TIME_W-1:0]      s2_now_r;
  logic signed [DZ_W-1:0] s2_axial_dz_r;
  logic signed [DZ_W-1:0] s2_yaw_dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_btn_r      <= s1_btn_r;
      s2_now_r      <= s1_now_r;
      s2_axial_dz_r <= axial_dz;
      s2_yaw_dz_r   <= yaw_dz;
    end
  end

  // ---------------------------------------------------------------------------
  // Targets and accel steps
  // ---------------------------------------------------------------------------
  function automatic logic signed [SPEED_W-1:0] sat_speed(
    input logic signed [ShiftedW-1:0] v
  );
    logic signed [ShiftedW-1:0] hi;
    logic signed [ShiftedW-1:0] lo;
    hi = ShiftedW'({1'b0, {(SPEED_W - 1){1'b1}}});
    lo = -hi - ShiftedW'(1);
    if (v > hi) begin
      return {1'b0, {(SPEED_W - 1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(SPEED_W - 1){1'b0}}};
    end
    return v[SPEED_W-1:0];
  endfunction

  // stored speed >> F (floor), clipped to the 11-bit field
  function automatic logic signed [OUT_W-1:0] speed_field(
    input logic signed [SPEED_W-1:0] v
  );
    logic signed [SPEED_W-1:0] sh;
    sh = v >>> FRACTION_BITS;
    if (sh > SPEED_W'(OUT_MAX)) begin
      return OUT_W'(OUT_MAX);
    end else if (sh < SPEED_W'(OUT_MIN)) begin
      return OUT_W'(OUT_MIN);
    end
    return sh[OUT_W-1:0];
  endfunction

  logic signed [ProdW-1:0]   pot_ax_prod;
  logic signed [ProdW-1:0]   pot_yw_prod;
  logic signed [SPEED_W-1:0] tgt_axial;
  logic signed [SPEED_W-1:0] tgt_yaw;
  logic [STEP_W-1:0]         step_axial;
  logic [STEP_W-1:0]         step_yaw;
  logic signed [SPEED_W-1:0] btn_axial;

  assign pot_ax_prod = top_axial * s2_axial_dz_r;
  assign pot_yw_prod = top_yaw * s2_yaw_dz_r;

  always_comb begin
    // button axial target
    if (s2_btn_r.forward) begin
      btn_axial = top_axial;
    end else if (s2_btn_r.reverse) begin
      btn_axial = -top_axial;
    end else begin
      btn_axial = '0;
    end

    if (pot_mode_r) begin
      tgt_axial  = sat_speed($signed(pot_ax_prod[ProdW-1:PRODUCT_SHIFT]));
      tgt_yaw    = sat_speed($signed(pot_yw_prod[ProdW-1:PRODUCT_SHIFT]));
      step_axial = STEP_W'(POT_ACCEL);
      step_yaw   = STEP_W'(POT_ACCEL);
    end else begin
      tgt_axial  = btn_axial;
      step_axial = (s2_btn_r.forward || s2_btn_r.reverse) ?
                   STEP_W'(AccAxDrive) : STEP_W'(AccAxStop);
      // turning while driving becomes a slower sweep
      if (s2_btn_r.right || s2_btn_r.left) begin
        if (btn_axial == '0) begin
          tgt_yaw  = s2_btn_r.right ? top_yaw : -top_yaw;
          step_yaw = STEP_W'(AccYawTurn);
        end else begin
          tgt_yaw  = s2_btn_r.right ? top_sweep : -top_sweep;
          step_yaw = STEP_W'(AccYawSweep);
        end
      end else begin
        tgt_yaw  = '0;
        step_yaw = STEP_W'(AccYawStop);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stop handling and slew state
  // ---------------------------------------------------------------------------
  logic                      stop_pending_r,  stop_pending_nxt;
  logic                      stop_active_r,   stop_active_nxt;
  logic [TIME_W-1:0]         stop_press_time_r, stop_press_time_nxt;
  logic signed [SPEED_W-1:0] limited_axial_r, limited_axial_nxt;
  logic signed [SPEED_W-1:0] limited_yaw_r,   limited_yaw_nxt;

  logic                      first_press;
  logic [TIME_W-1:0]         elapsed;
  logic signed [SPEED_W-1:0] cur_axial;
  logic signed [SPEED_W-1:0] cur_yaw;
  logic signed [SPEED_W-1:0] slew_axial;
  logic signed [SPEED_W-1:0] slew_yaw;

  // first press zeroes the stored speeds before this tick's slew
  assign first_press = s2_btn_r.stop && !stop_pending_r;
  assign elapsed     = s2_now_r - stop_press_time_r;
  assign cur_axial   = first_press ? '0 : limited_axial_r;
  assign cur_yaw     = first_press ? '0 : limited_yaw_r;

  jssl_slew u_slew_axial (
    .target  (tgt_axial),
    .current (cur_axial),
    .step    (step_axial),
    .next    (slew_axial)
  );

  jssl_slew u_slew_yaw (
    .target  (tgt_yaw),
    .current (cur_yaw),
    .step    (step_yaw),
    .next    (slew_yaw)
  );

  result_t    word0;
  result_t    word1;
  result_t    final_word;
  logic [1:0] push_cnt;

  always_comb begin
    stop_pending_nxt    = stop_pending_r;
    stop_active_nxt     = stop_active_r;
    stop_press_time_nxt = stop_press_time_r;
    limited_axial_nxt   = limited_axial_r;
    limited_yaw_nxt     = limited_yaw_r;
    final_word          = '0;
    word0               = '0;
    word1               = '0;
    push_cnt            = 2'd0;

    // disabled: tick is dropped, state kept
    if (s2_go && enable_r) begin
      if (s2_btn_r.stop) begin
        if (stop_pending_r) begin
          if (elapsed > TIME_W'(stop_hold_ms_r)) begin
            stop_active_nxt = 1'b1;
          end
        end else begin
          stop_press_time_nxt = s2_now_r;
          stop_pending_nxt    = 1'b1;
        end
      end else begin
        stop_pending_nxt = 1'b0;
        stop_active_nxt  = 1'b0;
      end

      if (stop_active_nxt) begin
        limited_axial_nxt = '0;
        limited_yaw_nxt   = '0;
        final_word = '{kind: CMD_ESTOP, axial: '0, yaw: '0, last: 1'b1};
      end else begin
        limited_axial_nxt = slew_axial;
        limited_yaw_nxt   = slew_yaw;
        final_word = '{kind: CMD_SPEED, axial: speed_field(slew_axial),
                       yaw: speed_field(slew_yaw), last: 1'b1};
      end

      if (first_press) begin
        word0    = '{kind: CMD_SPEED, axial: '0, yaw: '0, last: 1'b0};
        word1    = final_word;
        push_cnt = 2'd2;
      end else begin
        word0    = final_word;
        push_cnt = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_pending_r    <= 1'b0;
      stop_active_r     <= 1'b0;
      stop_press_time_r <= '0;
      limited_axial_r   <= '0;
      limited_yaw_r     <= '0;
    end else begin
      stop_pending_r    <= stop_pending_nxt;
      stop_active_r     <= stop_active_nxt;
      stop_press_time_r <= stop_press_time_nxt;
      limited_axial_r   <= limited_axial_nxt;
      limited_yaw_r     <= limited_yaw_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue: up to two words written per cycle, one read
  // ---------------------------------------------------------------------------
  result_t         fifo_r [FIFO_DEPTH];
  logic [PtrW-1:0] head_r, head_nxt;
  logic [PtrW-1:0] tail_r, tail_nxt;
  logic [CntW-1:0] cnt_nxt;
  logic [PtrW-1:0] tail_p1;
  logic            pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !out_stall;
  assign tail_p1   = tail_r + PtrW'(1);
  assign head_nxt  = pop ? head_r + PtrW'(1) : head_r;
  assign tail_nxt  = tail_r + PtrW'(push_cnt);
  assign cnt_nxt   = cnt_r + CntW'(push_cnt) - CntW'(pop);

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      fifo_r[tail_r] <= word0;
    end
    if (push_cnt == 2'd2) begin
      fifo_r[tail_p1] <= word1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign out_command_kind = fifo_r[head_r].kind;
  assign out_axial_speed  = fifo_r[head_r].axial;
  assign out_yaw_speed    = fifo_r[head_r].yaw;
  assign out_last_of_tick = fifo_r[head_r].last;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(FIFO_DEPTH))
    else $error("result queue overfilled");

  a_active_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
    stop_active_r |-> stop_pending_r)
    else $error("estop active without a pending press");

  a_estop_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_command_kind == CMD_ESTOP) |->
      (out_axial_speed == '0 && out_yaw_speed == '0 && out_last_of_tick))
    else $error("estop word with nonzero speed or not last");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s2_valid_r && !s2_go))
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

// ===== hw/rtl/jssl_deadband.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Centered deadband with rescale to full scale; output is already negated.
module jssl_deadband import jssl_pkg::*; #(
  parameter int DEADBAND_WIDTH = DEADBAND_WIDTH_DEF
) (
  input  logic [SAMPLE_W-1:0]    sample,
  input  logic [SAMPLE_W-1:0]    center,
  output logic signed [DZ_W-1:0] axis
);

  localparam int Divisor = DZ_FULL_SCALE - DEADBAND_WIDTH;
  // ceil(2^(S+11) / Divisor): exact floor division for 12-bit excess values
  localparam longint unsigned Recip =
      ((64'd1 << (RECIP_SHIFT + DZ_SCALE_LOG2)) + longint'(Divisor) - 64'd1)
      / longint'(Divisor);
  localparam logic [RECIP_W-1:0]  RecipW = RECIP_W'(Recip);
  localparam logic [SAMPLE_W:0]   DwW    = (SAMPLE_W + 1)'(DEADBAND_WIDTH);
  localparam int                  ProdW  = SAMPLE_W + RECIP_W;

  logic signed [SAMPLE_W:0] diff;
  logic [SAMPLE_W:0]        mag_ext;
  logic [SAMPLE_W-1:0]      excess;
  logic                     above;
  logic [ProdW-1:0]         prod;
  logic [DZ_W-2:0]          quot;

  assign diff    = $signed({1'b0, sample}) - $signed({1'b0, center});
  assign mag_ext = diff[SAMPLE_W] ? $unsigned(-diff) : $unsigned(diff);
  assign above   = mag_ext > DwW;
  assign excess  = mag_ext[SAMPLE_W-1:0] - DwW[SAMPLE_W-1:0];
  assign prod    = ProdW'(excess) * ProdW'(RecipW);
  assign quot    = prod[ProdW-1:RECIP_SHIFT];

  always_comb begin
    if (!above) begin
      axis = '0;
    end else if (diff[SAMPLE_W]) begin
      axis = $signed({1'b0, quot});
    end else begin
      axis = -$signed({1'b0, quot});
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/jssl_slew.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One axis: current moves toward target by at most step (2x to 0, min 1).
module jssl_slew import jssl_pkg::*; (
  input  logic signed [SPEED_W-1:0] target,
  input  logic signed [SPEED_W-1:0] current,
  input  logic [STEP_W-1:0]         step,
  output logic signed [SPEED_W-1:0] next
);

  logic [STEP_W:0]          step_eff;
  logic signed [SPEED_W:0]  diff;
  logic signed [SPEED_W:0]  step_s;
  logic signed [SPEED_W:0]  up;
  logic signed [SPEED_W:0]  down;

  always_comb begin
    // ramp to zero twice as hard
    step_eff = (target == '0) ? {step, 1'b0} : {1'b0, step};
    if (step_eff == '0) begin
      step_eff = (STEP_W + 1)'(1);
    end
  end

  assign step_s = $signed((SPEED_W + 1)'(step_eff));
  assign diff   = {target[SPEED_W-1], target} - {current[SPEED_W-1], current};
  assign up     = {current[SPEED_W-1], current} + step_s;
  assign down   = {current[SPEED_W-1], current} - step_s;

  always_comb begin
    if (diff > step_s) begin
      next = up[SPEED_W-1:0];
    end else if (diff < -step_s) begin
      next = down[SPEED_W-1:0];
    end else begin
      next = target;
    end
  end

endmodule

`default_nettype wire
